// ===== hw/rtl/iuv_pkg.sv =====
// ----------------------------------------------------------------------------
// iuv_pkg
// Shared types and constants for the image upload validator: request
// payloads, config record, mode and error codes, header constants.
// ----------------------------------------------------------------------------
package iuv_pkg;

	// header and storage geometry
	localparam int unsigned HEADER_LEN  = 32;
	localparam int unsigned STORE_BYTES = 131072;
	localparam int unsigned STORE_W     = $clog2(STORE_BYTES) + 1;

	// header constants
	localparam logic [31:0] MAGIC_WORD  = 32'h3149_4D54;
	localparam logic [15:0] HDR_VERSION = 16'd1;
	localparam logic [15:0] HDR_FORMAT  = 16'd1;

	// crc-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// config reset values
	localparam logic [15:0] RST_WIDTH         = 16'd240;
	localparam logic [15:0] RST_HEIGHT        = 16'd240;
	localparam logic [16:0] RST_PAYLOAD_BYTES = 17'd115200;

	// config register indexes
	typedef enum logic [1:0] {
		REG_WIDTH         = 2'd0,
		REG_HEIGHT        = 2'd1,
		REG_PAYLOAD_BYTES = 2'd2
	} reg_idx_t;

	// request modes
	typedef enum logic [1:0] {
		MODE_BEGIN = 2'd0,
		MODE_DATA  = 2'd1,
		MODE_END   = 2'd2,
		MODE_ABORT = 2'd3
	} mode_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_NOT_STARTED = 3'd1,
		ERR_BAD_HEADER  = 3'd2,
		ERR_TOO_LARGE   = 3'd3,
		ERR_NO_HEADER   = 3'd4,
		ERR_BAD_LENGTH  = 3'd5,
		ERR_CRC         = 3'd6,
		ERR_ABORTED     = 3'd7
	} err_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic        write_valid;
		logic [16:0] write_offset;
		logic [7:0]  write_byte;
		logic        upload_done;
		logic        item_failed;
		err_t        error_code;
	} result_t;

	typedef struct packed {
		logic [15:0] expected_width;
		logic [15:0] expected_height;
		logic [16:0] expected_payload_bytes;
	} cfg_t;

endpackage

// ===== hw/rtl/iuv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// iuv_cfg_regs
// Configuration register file: expected width, height and payload length.
// ----------------------------------------------------------------------------
module iuv_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [16:0]   cfg_data,
	output iuv_pkg::cfg_t cfg
);
	import iuv_pkg::*;

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_width         <= RST_WIDTH;
			cfg_q.expected_height        <= RST_HEIGHT;
			cfg_q.expected_payload_bytes <= RST_PAYLOAD_BYTES;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:         cfg_q.expected_width <= cfg_data[15:0];
				REG_HEIGHT:        cfg_q.expected_height <= cfg_data[15:0];
				REG_PAYLOAD_BYTES: cfg_q.expected_payload_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/iuv_crc8.sv =====
// ----------------------------------------------------------------------------
// iuv_crc8
// One byte step of the reflected crc-32, unrolled over eight bit steps.
// ----------------------------------------------------------------------------
module iuv_crc8 (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data_byte,
	output logic [31:0] crc_out
);
	import iuv_pkg::*;

	// shift out eight bits, folding the polynomial on each set lsb
	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data_byte};
		for (int k = 0; k < 8; k++) begin
			c = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
		end
		crc_out = c;
	end

endmodule

// ===== hw/rtl/iuv_core.sv =====
// ----------------------------------------------------------------------------
// iuv_core
// Upload state and per-request decision logic: header check, payload
// writes with overflow check, crc fold and end-of-upload checks.
// ----------------------------------------------------------------------------
module iuv_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  iuv_pkg::item_t   item,
	input  iuv_pkg::cfg_t    cfg,
	output iuv_pkg::result_t res
);
	import iuv_pkg::*;

	logic        active_q,   active_d;
	logic        failed_q,   failed_d;
	logic [5:0]  hdr_cnt_q,  hdr_cnt_d;
	logic        match_q,    match_d;
	logic        complete_q, complete_d;
	logic [31:0] hdr_crc_q,  hdr_crc_d;
	logic [16:0] pay_cnt_q,  pay_cnt_d;
	logic [31:0] crc_q,      crc_d;
	err_t        last_err_q, last_err_d;

	logic [31:0]        crc_next;
	logic [7:0]         want;
	logic               byte_ok;
	logic [STORE_W-1:0] offset;
	logic               too_large;

	iuv_crc8 u_crc8 (
		.crc_in    (crc_q),
		.data_byte (item.data_byte),
		.crc_out   (crc_next)
	);

	// expected value of the current header byte
	always_comb begin
		want    = 8'd0;
		byte_ok = 1'b1;
		case (hdr_cnt_q[4:0])
			5'd0:  want = MAGIC_WORD[7:0];
			5'd1:  want = MAGIC_WORD[15:8];
			5'd2:  want = MAGIC_WORD[23:16];
			5'd3:  want = MAGIC_WORD[31:24];
			5'd4:  want = HDR_VERSION[7:0];
			5'd5:  want = HDR_VERSION[15:8];
			5'd6:  want = HDR_FORMAT[7:0];
			5'd7:  want = HDR_FORMAT[15:8];
			5'd8:  want = cfg.expected_width[7:0];
			5'd9:  want = cfg.expected_width[15:8];
			5'd10: want = cfg.expected_height[7:0];
			5'd11: want = cfg.expected_height[15:8];
			5'd12: want = cfg.expected_payload_bytes[7:0];
			5'd13: want = cfg.expected_payload_bytes[15:8];
			5'd14: want = {7'd0, cfg.expected_payload_bytes[16]};
			5'd15: want = 8'd0;
			default: want = item.data_byte;
		endcase
		byte_ok = (want == item.data_byte);
	end

	// payload offset and overflow check
	assign offset    = STORE_W'(pay_cnt_q) + STORE_W'(HEADER_LEN);
	assign too_large = (pay_cnt_q >= cfg.expected_payload_bytes)
	                || (offset >= STORE_W'(STORE_BYTES));

	// next state and result
	always_comb begin
		active_d   = active_q;
		failed_d   = failed_q;
		hdr_cnt_d  = hdr_cnt_q;
		match_d    = match_q;
		complete_d = complete_q;
		hdr_crc_d  = hdr_crc_q;
		pay_cnt_d  = pay_cnt_q;
		crc_d      = crc_q;
		last_err_d = last_err_q;
		res        = '0;
		case (item.mode)
			MODE_BEGIN: begin
				active_d   = 1'b1;
				failed_d   = 1'b0;
				hdr_cnt_d  = '0;
				match_d    = 1'b1;
				complete_d = 1'b0;
				hdr_crc_d  = '0;
				pay_cnt_d  = '0;
				crc_d      = CRC_INIT;
				last_err_d = ERR_NONE;
			end
			MODE_ABORT: begin
				active_d         = 1'b0;
				failed_d         = 1'b1;
				last_err_d       = ERR_ABORTED;
				res.item_failed  = 1'b1;
				res.error_code   = ERR_ABORTED;
			end
			default: begin
				if (!active_q) begin
					// data or end with no upload open
					failed_d        = 1'b1;
					last_err_d      = ERR_NOT_STARTED;
					res.item_failed = 1'b1;
					res.error_code  = ERR_NOT_STARTED;
				end else if (item.mode == MODE_DATA) begin
					if (failed_q) begin
						res.item_failed = 1'b1;
						res.error_code  = last_err_q;
					end else if (!hdr_cnt_q[5]) begin
						// header byte
						match_d   = match_q & byte_ok;
						hdr_cnt_d = hdr_cnt_q + 6'd1;
						if (hdr_cnt_q[4:2] == 3'b100) begin
							hdr_crc_d[8*hdr_cnt_q[1:0] +: 8] = item.data_byte;
						end
						if (hdr_cnt_q[4:0] == 5'd31) begin
							complete_d = 1'b1;
							if (!match_d) begin
								failed_d        = 1'b1;
								last_err_d      = ERR_BAD_HEADER;
								res.item_failed = 1'b1;
								res.error_code  = ERR_BAD_HEADER;
							end
						end
					end else if (too_large) begin
						failed_d        = 1'b1;
						last_err_d      = ERR_TOO_LARGE;
						res.item_failed = 1'b1;
						res.error_code  = ERR_TOO_LARGE;
					end else begin
						// payload byte
						res.write_valid  = 1'b1;
						res.write_offset = offset[16:0];
						res.write_byte   = item.data_byte;
						crc_d            = crc_next;
						pay_cnt_d        = pay_cnt_q + 17'd1;
					end
				end else begin
					// end of upload checks
					active_d        = 1'b0;
					res.item_failed = 1'b1;
					if (failed_q) begin
						res.error_code = last_err_q;
					end else if (!complete_q) begin
						failed_d       = 1'b1;
						last_err_d     = ERR_NO_HEADER;
						res.error_code = ERR_NO_HEADER;
					end else if (pay_cnt_q != cfg.expected_payload_bytes) begin
						failed_d       = 1'b1;
						last_err_d     = ERR_BAD_LENGTH;
						res.error_code = ERR_BAD_LENGTH;
					end else if (~crc_q != hdr_crc_q) begin
						failed_d       = 1'b1;
						last_err_d     = ERR_CRC;
						res.error_code = ERR_CRC;
					end else begin
						res.item_failed = 1'b0;
						res.upload_done = 1'b1;
					end
				end
			end
		endcase
	end

	// upload state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			failed_q   <= 1'b0;
			hdr_cnt_q  <= '0;
			match_q    <= 1'b1;
			complete_q <= 1'b0;
			hdr_crc_q  <= '0;
			pay_cnt_q  <= '0;
			crc_q      <= CRC_INIT;
			last_err_q <= ERR_NONE;
		end else if (fire) begin
			active_q   <= active_d;
			failed_q   <= failed_d;
			hdr_cnt_q  <= hdr_cnt_d;
			match_q    <= match_d;
			complete_q <= complete_d;
			hdr_crc_q  <= hdr_crc_d;
			pay_cnt_q  <= pay_cnt_d;
			crc_q      <= crc_d;
			last_err_q <= last_err_d;
		end
	end

endmodule

// ===== hw/rtl/image_upload_validator.sv =====
// ----------------------------------------------------------------------------
// image_upload_validator
// Byte-wide upload checker: parses a 32-byte header, emits payload writes,
// folds payload into crc-32 and reports a result for every request.
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  item_t   (mode, data_byte)
//   result    out        result_valid/stall     result_t (write, status)
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One request per cycle while result_stall is low; the edge that takes a
// request loads the input register, and the result register then takes the
// core's answer for it and raises result_valid.
// The per-byte crc step and header compare sit between those two registers.
// Reset clears the upload state and loads the config defaults.
// A stalled result holds the result register and, once the input register
// is also full, item_stall goes high.
// ----------------------------------------------------------------------------
module image_upload_validator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  iuv_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output iuv_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [16:0]      cfg_data
);
	import iuv_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    advance;
	logic    fire;
	cfg_t    cfg;
	result_t core_res;

	// pipeline flow control
	assign advance    = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	iuv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	iuv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (core_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= core_res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ===== hw/rtl/iuv_checker.sv =====
// ----------------------------------------------------------------------------
// iuv_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module iuv_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             result_valid,
	input  logic             result_stall,
	input  iuv_pkg::result_t result
);
	import iuv_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// failure flag and error code agree
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.item_failed == (result.error_code != ERR_NONE)))
		else $error("item_failed and error_code disagree");

	// a payload write is never a failure or a completion
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_valid |->
			!result.item_failed && !result.upload_done)
		else $error("write reported with status");

	// payload writes land past the header, done never with failure
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(!result.write_valid || result.write_offset >= 17'(HEADER_LEN)) &&
			!(result.upload_done && result.item_failed))
		else $error("bad write offset or status");

endmodule

bind image_upload_validator iuv_checker u_iuv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
